// File: sv/bignum_short_divide_stream_assert.svh
// assertion macros for the short divide stream
`ifndef BIGNUM_SHORT_DIVIDE_STREAM_ASSERT_SVH
`define BIGNUM_SHORT_DIVIDE_STREAM_ASSERT_SVH

`ifndef SYNTHESIS

`define BSDS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: lbl");

`define BSDS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: lbl");

`else

`define BSDS_ASSERT(lbl, clk, rst_n, prop)
`define BSDS_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

// File: sv/bsds_pkg.sv
package bsds_pkg;

    localparam int HALF_DIGIT_BITS = 15;
    localparam int MAX_DIGITS      = 64;

    localparam int DIGIT_BITS = 2 * HALF_DIGIT_BITS;
    localparam int DIV_W      = 15;
    localparam int IDX_W      = 7;
    localparam int REM_W      = DIV_W + 1;
    localparam int CNT_W      = $clog2(DIGIT_BITS);

    typedef struct packed {
        logic [DIGIT_BITS-1:0] digit;
        logic [IDX_W-1:0]      digit_index;
        logic [DIV_W-1:0]      divisor;
        logic                  negative;
        logic                  first;
    } t_in_req;

    typedef struct packed {
        logic [DIGIT_BITS-1:0]   quotient_digit;
        logic [IDX_W-1:0]        out_index;
        logic signed [REM_W-1:0] remainder;
        logic [IDX_W-1:0]        top_index;
        logic                    quotient_negative;
        logic                    last;
    } t_out_req;

endpackage

// File: sv/bignum_short_divide_stream.sv
// a request is accepted in the idle state; the divide state then makes one quotient bit
// per step on the shared 16-bit compare/subtract unit, and the finish state writes the
// output register; no new request is taken until the finish state returns to idle
// a finished result waits in the output register while the next request is taken;
// a stalled result still in that register holds the finish cycle
// reset (synchronous, active low): remainder 0, divisor 1, sign 0, no nonzero digit seen
`include "bignum_short_divide_stream_assert.svh"

module bignum_short_divide_stream
    import bsds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    t_state                r_state;
    logic [DIV_W-1:0]      r_rem;
    logic [DIV_W-1:0]      r_div;
    logic                  r_sign;
    logic [IDX_W-1:0]      r_high;
    logic [DIGIT_BITS-1:0] r_digit;
    logic [DIGIT_BITS-1:0] r_quo;
    logic [IDX_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_out_valid;
    t_out_req              r_out_req;

    logic                  in_accept;
    logic [DIV_W-1:0]      n_div;
    logic [DIV_W-1:0]      base_rem;
    logic [DIV_W-1:0]      n_rem_start;
    logic [REM_W-1:0]      trial;
    logic [REM_W-1:0]      div_ext;
    logic [REM_W-1:0]      diff;
    logic                  ge;
    logic [DIV_W-1:0]      n_rem_step;
    logic [IDX_W-1:0]      rec_idx;
    logic [IDX_W-1:0]      n_high;
    logic [REM_W-1:0]      rem_ext;
    logic                  out_free;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // divisor and sign latch at the first digit; zero divisor acts as one
    always_comb begin
        if (i_in_req.first) begin
            n_div    = (i_in_req.divisor == '0) ? DIV_W'(1) : i_in_req.divisor;
            base_rem = '0;
        end else begin
            n_div    = r_div;
            base_rem = r_rem;
        end
        n_rem_start = (base_rem >= n_div) ? '0 : base_rem;
    end

    // shared shift-subtract unit: one quotient bit per cycle
    always_comb begin
        trial      = {r_rem, r_digit[DIGIT_BITS-1]};
        div_ext    = {1'b0, r_div};
        diff       = trial - div_ext;
        ge         = (trial >= div_ext);
        n_rem_step = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_comb begin
        rec_idx = (r_idx > IDX_W'(MAX_DIGITS)) ? IDX_W'(MAX_DIGITS) : r_idx;
        n_high  = ((r_quo != '0) && (rec_idx > r_high)) ? rec_idx : r_high;
        rem_ext = {1'b0, r_rem};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rem       <= '0;
            r_div       <= DIV_W'(1);
            r_sign      <= 1'b0;
            r_high      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the finish state refills the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_div   <= n_div;
                        r_rem   <= n_rem_start;
                        r_digit <= i_in_req.digit;
                        r_idx   <= i_in_req.digit_index;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        if (i_in_req.first) begin
                            r_sign <= i_in_req.negative;
                            r_high <= '0;
                        end
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem   <= n_rem_step;
                    r_quo   <= {r_quo[DIGIT_BITS-2:0], ge};
                    r_digit <= {r_digit[DIGIT_BITS-2:0], 1'b0};
                    r_cnt   <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIGIT_BITS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_high                   <= n_high;
                        r_out_valid              <= 1'b1;
                        r_out_req.quotient_digit <= r_quo;
                        r_out_req.out_index      <= r_idx;
                        if (r_idx == IDX_W'(1)) begin
                            r_out_req.remainder <= r_sign ? $signed(REM_W'(0) - rem_ext)
                                                          : $signed(rem_ext);
                            r_out_req.top_index <= (n_high == '0) ? IDX_W'(1) : n_high;
                            r_out_req.quotient_negative <= r_sign && (n_high != '0);
                            r_out_req.last      <= 1'b1;
                        end else begin
                            r_out_req.remainder         <= '0;
                            r_out_req.top_index         <= '0;
                            r_out_req.quotient_negative <= 1'b0;
                            r_out_req.last              <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    `BSDS_ASSERT_NEXT(a_accept_starts_div, i_clk, i_rst_n, in_accept, r_state == S_DIV)
    `BSDS_ASSERT(a_rem_below_div, i_clk, i_rst_n, (r_state != S_DIV) || (r_rem < r_div))
    `BSDS_ASSERT(a_div_nonzero, i_clk, i_rst_n, r_div != '0)
    `BSDS_ASSERT_NEXT(a_fin_waits, i_clk, i_rst_n,
                      (r_state == S_FIN) && r_out_valid && i_out_stall, r_state == S_FIN)

endmodule

// File: test/bignum_short_divide_stream_checker.sv
module bignum_short_divide_stream_checker
    import bsds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_in_req  i_in_req,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_req i_out_req,
    output int       o_fail_count,
    output int       o_waiting,
    output int       o_checked,
    output int       o_finals
);

    // divider state as the block should hold it
    logic [DIV_W-1:0] held_rem;
    logic [DIV_W-1:0] held_div;
    logic             held_neg;
    logic [IDX_W-1:0] top_seen;

    t_out_req due_quotients[$];

    always @(posedge i_clk) begin
        logic [DIGIT_BITS+DIV_W-1:0] dividend;
        logic [DIGIT_BITS+DIV_W-1:0] quo;
        logic [DIV_W-1:0]            div_now;
        logic [IDX_W-1:0]            idx;
        logic [IDX_W-1:0]            capped;
        logic [REM_W-1:0]            rem_ext;
        t_out_req                    want;
        if (!i_rst_n) begin
            held_rem = '0;
            held_div = DIV_W'(1);
            held_neg = 1'b0;
            top_seen = '0;
            due_quotients.delete();
            o_fail_count = 0;
            o_waiting = 0;
            o_checked = 0;
            o_finals = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_in_req.first) begin
                    held_div = i_in_req.divisor;
                    held_neg = i_in_req.negative;
                    held_rem = '0;
                    top_seen = '0;
                end
                div_now = (held_div == '0) ? DIV_W'(1) : held_div;
                if (held_rem >= div_now)
                    held_rem = '0;
                dividend = {held_rem, i_in_req.digit};
                quo = dividend / div_now;
                held_rem = DIV_W'(dividend % div_now);
                idx = i_in_req.digit_index;
                capped = (idx > MAX_DIGITS) ? IDX_W'(MAX_DIGITS) : idx;
                if (quo != '0 && capped > top_seen)
                    top_seen = capped;
                want = '0;
                want.quotient_digit = quo[DIGIT_BITS-1:0];
                want.out_index = idx;
                // summary fields only ride on the least significant digit
                if (idx == IDX_W'(1)) begin
                    rem_ext = {1'b0, held_rem};
                    want.remainder = held_neg ? -rem_ext : rem_ext;
                    want.top_index = (top_seen == '0) ? IDX_W'(1) : top_seen;
                    want.quotient_negative = held_neg && (top_seen != '0);
                    want.last = 1'b1;
                end
                due_quotients.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_quotients.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result q=%h idx=%0d with nothing pending",
                                 i_out_req.quotient_digit, i_out_req.out_index);
                end else begin
                    want = due_quotients.pop_front();
                    o_checked++;
                    if (want.last)
                        o_finals++;
                    if (i_out_req !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"mismatch on result %0d: expected q=%h idx=%0d rem=%0d ",
                                      "top=%0d neg=%b last=%b, got q=%h idx=%0d rem=%0d ",
                                      "top=%0d neg=%b last=%b"},
                                     o_checked, want.quotient_digit, want.out_index,
                                     want.remainder, want.top_index,
                                     want.quotient_negative, want.last,
                                     i_out_req.quotient_digit, i_out_req.out_index,
                                     i_out_req.remainder, i_out_req.top_index,
                                     i_out_req.quotient_negative, i_out_req.last);
                    end
                end
            end
            o_waiting = due_quotients.size();
        end
    end

endmodule

// File: test/bignum_short_divide_stream_tb.sv
module bignum_short_divide_stream_tb;
    import bsds_pkg::*;

    localparam int N_ITEMS   = 900;
    localparam int LIMIT     = 500000;
    localparam int DRAIN     = 40;
    localparam int DIGIT_MAX = (1 << DIGIT_BITS) - 1;
    localparam int DIV_MAX   = (1 << DIV_W) - 1;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    t_in_req  in_req = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_out_req out_req;

    int   fail_count;
    int   waiting;
    int   checked;
    int   finals;
    int   cycles = 0;
    int   sent_count = 0;
    logic idle_on = 1'b1;
    int   stall_left = 0;
    int   quiet_left = 0;

    always #5 i_clk = ~i_clk;

    bignum_short_divide_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req)
    );

    bignum_short_divide_stream_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_req    (out_req),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_checked    (checked),
        .o_finals     (finals)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending", cycles, waiting);
            $display("bignum_short_divide_stream_tb: done, errors");
            $finish;
        end
    end

    // receiver back-pressure: short stall bursts with quiet stretches between
    always @(negedge i_clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (quiet_left > 0)
            quiet_left--;
        else if (idle_on) begin
            case ($urandom_range(0, 15))
                0:       quiet_left = $urandom_range(20, 200);
                1, 2, 3: stall_left = $urandom_range(1, 4);
                default: ;
            endcase
        end
        out_stall <= idle_on && (stall_left > 0);
    end

    function automatic t_in_req mk(input logic [31:0] digit, input int idx, input int div,
                                   input logic neg, input logic first);
        t_in_req r;
        r.digit       = digit[DIGIT_BITS-1:0];
        r.digit_index = idx[IDX_W-1:0];
        r.divisor     = div[DIV_W-1:0];
        r.negative    = neg;
        r.first       = first;
        return r;
    endfunction

    function automatic logic [31:0] rand_digit();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return DIGIT_MAX;
            2:       return $urandom_range(0, 100);
            default: return $urandom() & DIGIT_MAX;
        endcase
    endfunction

    function automatic int rand_divisor();
        case ($urandom_range(0, 7))
            0:       return 1;
            1:       return DIV_MAX;
            2:       return $urandom_range(1, 15);
            3:       return 1 << $urandom_range(0, DIV_W - 1);
            default: return $urandom_range(1, DIV_MAX);
        endcase
    endfunction

    task automatic drive_request(input t_in_req r);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do
            @(posedge i_clk);
        while (in_stall);
        sent_count++;
    endtask

    // digits from index len down to index stop; stop above 1 leaves the number unfinished
    task automatic send_number(input int len, input int stop, input int div, input logic neg);
        for (int i = len; i >= stop; i--)
            drive_request(mk(rand_digit(), i, div, neg, i == len));
    endtask

    initial begin
        int len;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // digits with no leading first after reset divide by one
        drive_request(mk(DIGIT_MAX, 3, 0, 1'b1, 1'b0));
        drive_request(mk(0, 2, 0, 1'b0, 1'b0));
        drive_request(mk(12345, 1, 0, 1'b0, 1'b0));
        // zero divisor acts as one
        drive_request(mk(DIGIT_MAX, 2, 0, 1'b1, 1'b1));
        drive_request(mk(7, 1, 0, 1'b0, 1'b0));
        // largest divisor, all-ones digits, negative
        drive_request(mk(DIGIT_MAX, 3, DIV_MAX, 1'b1, 1'b1));
        drive_request(mk(DIGIT_MAX, 2, 0, 1'b0, 1'b0));
        drive_request(mk(DIGIT_MAX, 1, 0, 1'b0, 1'b0));
        // zero quotient reports positive with top index one
        drive_request(mk(5, 1, DIV_MAX, 1'b1, 1'b1));
        // indices past the digit limit and index zero
        drive_request(mk(1, 127, 1, 1'b0, 1'b1));
        drive_request(mk(0, 0, 1, 1'b0, 1'b0));
        drive_request(mk(3, 65, 1, 1'b0, 1'b0));
        drive_request(mk(0, 1, 1, 1'b0, 1'b0));
        // indices out of order cannot lower the top index
        drive_request(mk(0, 5, 3, 1'b1, 1'b1));
        drive_request(mk(7, 2, 0, 1'b0, 1'b0));
        drive_request(mk(9, 4, 0, 1'b0, 1'b0));
        drive_request(mk(0, 1, 0, 1'b0, 1'b0));
        // a new first in the middle restarts the division
        drive_request(mk(DIGIT_MAX, 3, 2, 1'b0, 1'b1));
        drive_request(mk(100, 2, 9, 1'b1, 1'b1));
        drive_request(mk(1, 1, 9, 1'b1, 1'b0));
        // single-digit number
        drive_request(mk(0, 1, 1, 1'b0, 1'b1));

        while (sent_count < N_ITEMS) begin
            if (sent_count > N_ITEMS - 100)
                idle_on = 1'b0;
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(33, 64);
                1, 2:    len = 1;
                default: len = $urandom_range(2, 8);
            endcase
            case ($urandom_range(0, 9))
                0:
                    drive_request(mk($urandom(), $urandom_range(0, 127),
                                     $urandom_range(0, DIV_MAX), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1))));
                1:
                    send_number(len + 1, $urandom_range(2, len + 1), rand_divisor(),
                                1'($urandom_range(0, 1)));
                default:
                    send_number(len, 1, rand_divisor(), 1'($urandom_range(0, 1)));
            endcase
        end
        @(negedge i_clk);
        in_valid <= 1'b0;

        while (waiting != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("sent %0d digit requests, checked %0d quotient digits", sent_count, checked);
        $display("%0d completed divisions with remainder and top index, %0d mismatches",
                 finals, fail_count);
        if (fail_count == 0 && waiting == 0)
            $display("bignum_short_divide_stream_tb: done, clean");
        else
            $display("bignum_short_divide_stream_tb: done, errors");
        $finish;
    end

endmodule

// File: bignum_short_divide_stream.f
+incdir+sv
sv/bsds_pkg.sv
sv/bignum_short_divide_stream.sv
test/bignum_short_divide_stream_checker.sv
test/bignum_short_divide_stream_tb.sv
